/* sv/sm64br_pkg.sv */
// shared types and constants of the splitmix64 bounded random block
package sm64br_pkg;

	localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
	localparam int unsigned SHIFT_A      = 30;
	localparam int unsigned SHIFT_B      = 27;
	localparam int unsigned SHIFT_C      = 31;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_THR_START,
		ST_THR_WAIT,
		ST_DRAW,
		ST_MULA_START,
		ST_MULA_WAIT,
		ST_MULB_START,
		ST_MULB_WAIT,
		ST_CHECK,
		ST_FIN_START,
		ST_FIN_WAIT,
		ST_EMIT
	} seq_state_t;

	// control into a shared unit
	typedef struct packed {
		logic start;
	} unit_ctl_t;

	// status back from a shared unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

/* sv/splitmix64_bounded_random.sv */
// top level: sequencer and datapath of the splitmix64 bounded random block
//
// Each item on the slave stream is an exclusive upper bound; the block answers one
// unbiased value below it on the master stream. A write on cfg_we loads the seed into
// the generator state at once (write only while idle). A bound of zero answers zero
// and leaves the state alone. Otherwise the block works out the rejection threshold
// (2^64 - bound) mod bound with a bit-serial remainder unit, then makes draws: the
// gamma add and first xor-shift, two multiplies (three partial products each on a
// shared 32 x 32 multiplier), and one compare. A draw below the threshold is thrown
// away and another made. The accepted draw goes through the remainder unit again.
// One item is in work at a time. The result sits in an output register, so the next
// item may be taken while it waits.
module splitmix64_bounded_random (
	input  logic        clk,
	input  logic        arst_n,
	// seed register write
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] bound
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // [63:0] value
);
	import sm64br_pkg::*;

	seq_state_t  state_q;
	seq_state_t  state_d;

	logic [63:0] gen_q;      // generator state
	logic [63:0] bound_q;
	logic [63:0] thr_q;      // rejection threshold
	logic [63:0] z_q;        // draw in progress
	logic [63:0] res_q;
	logic [63:0] out_data_q;
	logic        out_valid_q;

	unit_ctl_t   mul_ctl;
	unit_sts_t   mul_sts;
	unit_ctl_t   rem_ctl;
	unit_sts_t   rem_sts;
	logic [63:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] rem_dvd;
	logic [63:0] rem_r;

	logic        in_take;
	logic        out_load;
	logic [63:0] gen_next;

	assign in_take  = s_axis_tvalid && s_axis_tready;
	// in the emit state, with the output register free or being emptied this cycle
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
	assign gen_next = gen_q + GOLDEN_GAMMA;

	// shared units
	assign mul_b   = (state_q == ST_MULA_START) ? MIX_MUL_A : MIX_MUL_B;
	assign rem_dvd = (state_q == ST_THR_START) ? (64'd0 - bound_q) : z_q;

	sm64br_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl),
		.a       (z_q),
		.b       (mul_b),
		.sts     (mul_sts),
		.product (mul_p)
	);

	sm64br_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rem_ctl),
		.dividend  (rem_dvd),
		.divisor   (bound_q),
		.sts       (rem_sts),
		.remainder (rem_r)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_d = (s_axis_tdata == 64'd0) ? ST_EMIT : ST_THR_START;
				end
			end
			ST_THR_START:  state_d = ST_THR_WAIT;
			ST_THR_WAIT: begin
				if (rem_sts.done) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW:       state_d = ST_MULA_START;
			ST_MULA_START: state_d = ST_MULA_WAIT;
			ST_MULA_WAIT: begin
				if (mul_sts.done) begin
					state_d = ST_MULB_START;
				end
			end
			ST_MULB_START: state_d = ST_MULB_WAIT;
			ST_MULB_WAIT: begin
				if (mul_sts.done) begin
					state_d = ST_CHECK;
				end
			end
			// draws below the threshold are rejected
			ST_CHECK:      state_d = (z_q >= thr_q) ? ST_FIN_START : ST_DRAW;
			ST_FIN_START:  state_d = ST_FIN_WAIT;
			ST_FIN_WAIT: begin
				if (rem_sts.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		mul_ctl.start = (state_q == ST_MULA_START) || (state_q == ST_MULB_START);
		rem_ctl.start = (state_q == ST_THR_START) || (state_q == ST_FIN_START);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			gen_q       <= 64'd0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			// seed write loads the generator state
			if (cfg_we) begin
				gen_q <= cfg_wdata;
			end else if (state_q == ST_DRAW) begin
				gen_q <= gen_next;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_take) begin
			bound_q <= s_axis_tdata;
			res_q   <= 64'd0;
		end
		if ((state_q == ST_THR_WAIT) && rem_sts.done) begin
			thr_q <= rem_r;
		end
		if (state_q == ST_DRAW) begin
			z_q <= gen_next ^ (gen_next >> SHIFT_A);
		end else if ((state_q == ST_MULA_WAIT) && mul_sts.done) begin
			z_q <= mul_p ^ (mul_p >> SHIFT_B);
		end else if ((state_q == ST_MULB_WAIT) && mul_sts.done) begin
			z_q <= mul_p ^ (mul_p >> SHIFT_C);
		end
		if ((state_q == ST_FIN_WAIT) && rem_sts.done) begin
			res_q <= rem_r;
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* sv/sm64br_mul.sv */
// iterative 64 x 64 low-half multiplier on one shared 32 x 32 multiplier
module sm64br_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sm64br_pkg::unit_ctl_t ctl,
	input  logic [63:0]           a,
	input  logic [63:0]           b,
	output sm64br_pkg::unit_sts_t sts,
	output logic [63:0]           product
);
	import sm64br_pkg::*;

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_x;
	logic [31:0] op_y;
	logic [63:0] pp;

	// partial product order: lo*lo, lo*hi, hi*lo
	always_comb begin
		unique case (step_q)
			2'd0:    begin op_x = a_q[31:0];  op_y = b_q[31:0];  end
			2'd1:    begin op_x = a_q[31:0];  op_y = b_q[63:32]; end
			default: begin op_x = a_q[63:32]; op_y = b_q[31:0];  end
		endcase
	end

	assign pp = {32'd0, op_x} * {32'd0, op_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= 2'd0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= pp;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + pp[31:0];
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = acc_q;

endmodule

/* sv/sm64br_rem.sv */
// restoring 64-bit remainder unit, one quotient bit per cycle
module sm64br_rem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sm64br_pkg::unit_ctl_t ctl,
	input  logic [63:0]           dividend,
	input  logic [63:0]           divisor,
	output sm64br_pkg::unit_sts_t sts,
	output logic [63:0]           remainder
);
	import sm64br_pkg::*;

	logic [63:0] dvd_q;
	logic [63:0] dvs_q;
	logic [63:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] shifted;
	logic [64:0] diff;
	logic        take;

	assign shifted = {rem_q, dvd_q[63]};
	assign take    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			// partial remainder stays below the divisor, so 64 bits suffice
			rem_q <= take ? diff[63:0] : shifted[63:0];
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign remainder = rem_q;

endmodule

/* test/splitmix64_bounded_random_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the splitmix64 bounded random block
module splitmix64_bounded_random_tb;
	import sm64br_pkg::*;

	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
	localparam int STALL_LIMIT  = 5000;  // cycles with no item moving on either side
	localparam int TAIL_CYCLES  = 300;   // idle cycles after the last value has drained
	localparam int RANDOM_ITEMS = 1550;
	localparam int PHASE_ITEMS  = 250;   // a new seed at the start of each phase
	localparam int PLAN_ROWS    = 22;

	typedef enum logic {ROW_SEED, ROW_BOUND} row_kind_t;

	// one row of the directed plan: a seed write or a bound item
	typedef struct packed {
		row_kind_t   kind;
		logic [63:0] data;
		logic        known;   // value below is typed in, not predicted
		logic [63:0] value;
	} plan_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [63:0] cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;   // [63:0] bound
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;          // [63:0] value

	logic [63:0] mix_state;             // predicted generator state
	logic [63:0] pending_values[$];     // expected values, oldest first
	int          mismatch_count = 0;
	int          stall_cycles   = 0;
	bit          quiet          = 1'b0; // no idle gaps on either side
	bit          hold_req       = 1'b0;
	plan_row_t   plan [PLAN_ROWS];

	splitmix64_bounded_random uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// one splitmix64 step on the predicted state
	function automatic logic [63:0] next_draw();
		logic [63:0] z;
		mix_state = mix_state + GOLDEN_GAMMA;
		z = mix_state;
		z = (z ^ (z >> SHIFT_A)) * MIX_MUL_A;
		z = (z ^ (z >> SHIFT_B)) * MIX_MUL_B;
		return z ^ (z >> SHIFT_C);
	endfunction

	// unbiased value below bound by rejection; bound zero leaves the state alone
	function automatic logic [63:0] bounded_draw(input logic [63:0] bound);
		logic [63:0] threshold;
		logic [63:0] r;
		if (bound == 64'd0) begin
			return 64'd0;
		end
		threshold = (64'd0 - bound) % bound;
		do begin
			r = next_draw();
		end while (r < threshold);
		return r % bound;
	endfunction

	// bounds spread over small, power-of-two, worst-case rejection and wide values
	function automatic logic [63:0] pick_bound();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return 64'($urandom_range(0, 3));
			1, 2: return 64'($urandom_range(1, 16));
			3: return 64'd1 << $urandom_range(0, 63);
			4: return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 8)) - 64'd4;
			5: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 8));
			6: return wide >> $urandom_range(0, 63);
			default: return wide;
		endcase
	endfunction

	task automatic flag_error(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// offer one bound, predict its value once it is taken
	task automatic send_bound(input logic [63:0] bound, input logic known,
			input logic [63:0] value);
		int gap;
		logic [63:0] predicted;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= bound;
		do begin
			@(posedge clk);
		end while (s_axis_tready !== 1'b1);
		predicted = bounded_draw(bound);
		pending_values.push_back(known ? value : predicted);
	endtask

	// stop offering and let every expected value come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_values.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// seed writes only land while the block is idle
	task automatic write_seed(input logic [63:0] seed);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= seed;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mix_state = seed;
	endtask

	// stimulus: reset, directed plan, then random phases
	initial begin
		mix_state = 64'd0;
		plan = '{
			'{ROW_BOUND, 64'd0,                  1'b1, 64'd0},
			'{ROW_BOUND, 64'd1,                  1'b1, 64'd0},
			'{ROW_BOUND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
			'{ROW_BOUND, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
			'{ROW_BOUND, 64'h8000_0000_0000_0001, 1'b0, 64'd0},
			'{ROW_BOUND, 64'd2,                  1'b0, 64'd0},
			'{ROW_BOUND, 64'd3,                  1'b0, 64'd0},
			'{ROW_BOUND, 64'd7,                  1'b0, 64'd0},
			'{ROW_BOUND, 64'h0000_0001_0000_0000, 1'b0, 64'd0},
			'{ROW_BOUND, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
			'{ROW_SEED,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
			'{ROW_BOUND, 64'd0,                  1'b1, 64'd0},
			'{ROW_BOUND, 64'd1,                  1'b1, 64'd0},
			'{ROW_BOUND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
			'{ROW_BOUND, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
			'{ROW_SEED,  64'd0,                  1'b0, 64'd0},
			'{ROW_BOUND, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'd0},
			'{ROW_BOUND, 64'd10,                 1'b0, 64'd0},
			'{ROW_SEED,  64'h0123_4567_89AB_CDEF, 1'b0, 64'd0},
			'{ROW_BOUND, 64'd1,                  1'b1, 64'd0},
			'{ROW_BOUND, 64'd100,                1'b0, 64'd0},
			'{ROW_BOUND, 64'd0,                  1'b1, 64'd0}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SEED) begin
				write_seed(plan[i].data);
			end else begin
				send_bound(plan[i].data, plan[i].known, plan[i].value);
			end
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_ITEMS == 0) begin
				case (n / PHASE_ITEMS)
					1: write_seed(64'hFFFF_FFFF_FFFF_FFFF);
					2: write_seed(64'd0);
					default: write_seed({$urandom, $urandom});
				endcase
				// receiver stalls while items keep coming, so the input backs up
				if (n / PHASE_ITEMS == 3) begin
					hold_req = 1'b1;
				end
			end
			// one pause mid-run until everything has come out
			if (n == 4 * PHASE_ITEMS + PHASE_ITEMS / 2) begin
				wait_drained();
			end
			if (n % 40 == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			send_bound(pick_bound(), 1'b0, 64'd0);
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("splitmix64_bounded_random_tb: clean");
		end else begin
			$display("splitmix64_bounded_random_tb: errors");
		end
		$finish;
	end

	// result side: random back-pressure, one long hold on request, value check
	initial begin : result_sink
		int gap;
		logic [63:0] want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = quiet ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(posedge clk);
			end while (m_axis_tvalid !== 1'b1);
			if (pending_values.size() == 0) begin
				flag_error($sformatf("unexpected value %h", m_axis_tdata));
			end else begin
				want = pending_values.pop_front();
				if (m_axis_tdata !== want) begin
					flag_error($sformatf("value %h, expected %h", m_axis_tdata, want));
				end
			end
		end
	end

	// watchdog on cycles where no item moves
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
				(m_axis_tvalid === 1'b1 && m_axis_tready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles = stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("splitmix64_bounded_random_tb: errors");
			$finish;
		end
	end

endmodule
